### rtl/core/psd_pkg.sv
package psd_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int DIST_BITS   = 43;

    localparam int DW  = COORD_WIDTH + 1;
    localparam int PW  = 2 * DW;
    localparam int SW  = PW + 1;
    localparam int LW  = 2 * COORD_WIDTH + 1;
    localparam int CRW = 2 * COORD_WIDTH + 1;

    typedef enum logic [1:0] {
        REGION_BEGIN    = 2'd0,
        REGION_INTERIOR = 2'd1,
        REGION_END      = 2'd2
    } region_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] seg_begin_x;
        logic signed [COORD_WIDTH-1:0] seg_begin_y;
        logic signed [COORD_WIDTH-1:0] seg_end_x;
        logic signed [COORD_WIDTH-1:0] seg_end_y;
    } in_item_t;

    typedef struct packed {
        logic [DIST_BITS-1:0] dist_sq;
        region_t              region;
    } out_item_t;

    typedef struct packed {
        region_t       region;
        logic [LW-1:0] len;
        logic [LW-1:0] alt;
    } side_t;

endpackage

### rtl/core/psd_front.sv
module psd_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  logic                           in_valid,
    input  psd_pkg::in_item_t              query,
    output logic                           out_valid,
    output logic [psd_pkg::CRW-1:0]        cross_mag,
    output psd_pkg::side_t                 side
);

    localparam int DW  = psd_pkg::DW;
    localparam int PW  = psd_pkg::PW;
    localparam int SW  = psd_pkg::SW;
    localparam int LW  = psd_pkg::LW;
    localparam int CRW = psd_pkg::CRW;
    localparam int CW  = psd_pkg::COORD_WIDTH;

    logic [3:0] valid_reg;

    logic signed [DW-1:0] bx_reg, by_reg, vx_reg, vy_reg, dx_reg, dy_reg;
    logic signed [DW-1:0] bx_next, by_next, vx_next, vy_next, dx_next, dy_next;

    logic signed [PW-1:0] tx_reg, ty_reg, ca_reg, cb_reg;
    logic signed [PW-1:0] qvx_reg, qvy_reg, qbx_reg, qby_reg, qdx_reg, qdy_reg;

    logic signed [SW-1:0] t_reg, cross_reg;
    logic [LW-1:0]        len_reg, begin_reg, end_reg;
    logic signed [SW-1:0] t_next, cross_next, len_sum, begin_sum, end_sum;

    logic signed [SW-1:0] len_ext;
    logic signed [SW-1:0] cross_abs;
    logic [CRW-1:0]       cross_mag_reg, cross_mag_next;
    psd_pkg::side_t       side_reg, side_next;

    always_comb
    begin
        bx_next = {query.point_x[CW-1], query.point_x}
                - {query.seg_begin_x[CW-1], query.seg_begin_x};
        by_next = {query.point_y[CW-1], query.point_y}
                - {query.seg_begin_y[CW-1], query.seg_begin_y};
        vx_next = {query.seg_end_x[CW-1], query.seg_end_x}
                - {query.seg_begin_x[CW-1], query.seg_begin_x};
        vy_next = {query.seg_end_y[CW-1], query.seg_end_y}
                - {query.seg_begin_y[CW-1], query.seg_begin_y};
        dx_next = {query.point_x[CW-1], query.point_x}
                - {query.seg_end_x[CW-1], query.seg_end_x};
        dy_next = {query.point_y[CW-1], query.point_y}
                - {query.seg_end_y[CW-1], query.seg_end_y};
    end

    always_comb
    begin
        t_next     = SW'(tx_reg) + SW'(ty_reg);
        cross_next = SW'(ca_reg) - SW'(cb_reg);
        len_sum    = SW'(qvx_reg) + SW'(qvy_reg);
        begin_sum  = SW'(qbx_reg) + SW'(qby_reg);
        end_sum    = SW'(qdx_reg) + SW'(qdy_reg);
    end

    always_comb
    begin
        len_ext        = SW'(len_reg);
        cross_abs      = cross_reg[SW-1] ? -cross_reg : cross_reg;
        cross_mag_next = cross_abs[CRW-1:0];
        side_next.len  = len_reg;
        priority if (t_reg[SW-1] || (t_reg == '0))
        begin
            side_next.region = psd_pkg::REGION_BEGIN;
            side_next.alt    = begin_reg;
        end
        else if (t_reg >= len_ext)
        begin
            side_next.region = psd_pkg::REGION_END;
            side_next.alt    = end_reg;
        end
        else
        begin
            side_next.region = psd_pkg::REGION_INTERIOR;
            side_next.alt    = begin_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bx_reg        <= bx_next;
            by_reg        <= by_next;
            vx_reg        <= vx_next;
            vy_reg        <= vy_next;
            dx_reg        <= dx_next;
            dy_reg        <= dy_next;

            tx_reg        <= PW'(vx_reg) * PW'(bx_reg);
            ty_reg        <= PW'(vy_reg) * PW'(by_reg);
            ca_reg        <= PW'(vx_reg) * PW'(by_reg);
            cb_reg        <= PW'(vy_reg) * PW'(bx_reg);
            qvx_reg       <= PW'(vx_reg) * PW'(vx_reg);
            qvy_reg       <= PW'(vy_reg) * PW'(vy_reg);
            qbx_reg       <= PW'(bx_reg) * PW'(bx_reg);
            qby_reg       <= PW'(by_reg) * PW'(by_reg);
            qdx_reg       <= PW'(dx_reg) * PW'(dx_reg);
            qdy_reg       <= PW'(dy_reg) * PW'(dy_reg);

            t_reg         <= t_next;
            cross_reg     <= cross_next;
            len_reg       <= len_sum[LW-1:0];
            begin_reg     <= begin_sum[LW-1:0];
            end_reg       <= end_sum[LW-1:0];

            cross_mag_reg <= cross_mag_next;
            side_reg      <= side_next;
        end
    end

    assign out_valid = valid_reg[3];
    assign cross_mag = cross_mag_reg;
    assign side      = side_reg;

    a_interior_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[3] && (side_reg.region == psd_pkg::REGION_INTERIOR))
        |-> (side_reg.len != '0))
        else $error("interior region with zero segment length");

endmodule

### rtl/core/psd_square.sv
module psd_square (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [psd_pkg::CRW-1:0]       cross_mag,
    input  psd_pkg::side_t                in_side,
    output logic                          out_valid,
    output logic [2*psd_pkg::CRW-1:0]     cross_sq,
    output psd_pkg::side_t                out_side
);

    localparam int CRW = psd_pkg::CRW;
    localparam int H   = (CRW + 1) / 2;
    localparam int HI  = CRW - H;
    localparam int QSW = 2 * CRW;
    localparam int HHW = 2 * HI;
    localparam int HLW = HI + H;
    localparam int LLW = 2 * H;

    logic [1:0] valid_reg;

    logic [2*HI-1:0]  hh_reg;
    logic [HI+H-1:0]  hl_reg;
    logic [2*H-1:0]   ll_reg;
    psd_pkg::side_t   side_a_reg, side_b_reg;
    logic [QSW-1:0]   sq_reg, sq_next;

    always_comb
    begin
        sq_next = (QSW'(hh_reg) << (2 * H))
                + (QSW'(hl_reg) << (H + 1))
                + QSW'(ll_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hh_reg     <= HHW'(cross_mag[CRW-1:H]) * HHW'(cross_mag[CRW-1:H]);
            hl_reg     <= HLW'(cross_mag[CRW-1:H]) * HLW'(cross_mag[H-1:0]);
            ll_reg     <= LLW'(cross_mag[H-1:0]) * LLW'(cross_mag[H-1:0]);
            side_a_reg <= in_side;
            sq_reg     <= sq_next;
            side_b_reg <= side_a_reg;
        end
    end

    assign out_valid = valid_reg[1];
    assign cross_sq  = sq_reg;
    assign out_side  = side_b_reg;

endmodule

### rtl/core/psd_div.sv
module psd_div #(
    parameter int FRAC_BITS = 8
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     adv,
    input  logic                                     in_valid,
    input  logic [2*psd_pkg::CRW-1:0]                cross_sq,
    input  psd_pkg::side_t                           in_side,
    output logic                                     out_valid,
    output logic [psd_pkg::LW+FRAC_BITS-1:0]         quotient,
    output psd_pkg::side_t                           out_side
);

    localparam int LW  = psd_pkg::LW;
    localparam int QW  = LW + FRAC_BITS;
    localparam int NW  = 2 * psd_pkg::CRW + FRAC_BITS;

    logic [NW-1:0]   num;
    logic [LW-1:0]   rem0;
    logic [QW-1:0]   work0;

    logic [QW-1:0]   valid_reg;
    logic [LW-1:0]   rem_reg   [QW];
    logic [QW-1:0]   work_reg  [QW];
    psd_pkg::side_t  side_reg  [QW];

    logic [LW-1:0]   rem_next  [QW];
    logic [QW-1:0]   work_next [QW];
    psd_pkg::side_t  side_next [QW];

    assign num   = NW'(cross_sq) << FRAC_BITS;
    assign rem0  = num[NW-1:QW];
    assign work0 = num[QW-1:0];

    always_comb
    begin
        logic [LW-1:0]  pr;
        logic [QW-1:0]  pw;
        logic [LW:0]    trial;
        logic [LW:0]    diff;
        psd_pkg::side_t ps;
        for (int i = 0; i < QW; i++)
        begin
            if (i == 0)
            begin
                pr = rem0;
                pw = work0;
                ps = in_side;
            end
            else
            begin
                pr = rem_reg[i-1];
                pw = work_reg[i-1];
                ps = side_reg[i-1];
            end
            trial = {pr, pw[QW-1]};
            diff  = trial - {1'b0, ps.len};
            if (!diff[LW])
            begin
                rem_next[i]  = diff[LW-1:0];
                work_next[i] = {pw[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next[i]  = trial[LW-1:0];
                work_next[i] = {pw[QW-2:0], 1'b0};
            end
            side_next[i] = ps;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[QW-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < QW; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                work_reg[i] <= work_next[i];
                side_reg[i] <= side_next[i];
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign quotient  = work_reg[QW-1];
    assign out_side  = side_reg[QW-1];

    a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && adv && (in_side.region == psd_pkg::REGION_INTERIOR))
        |-> (rem0 < in_side.len))
        else $error("quotient overflows divider width");

endmodule

### rtl/core/point_segment_distance_squared_core.sv
// Squared distance from a query point to a 2D segment with signed integer
// coordinates. One query is taken per cycle while query_stall is low, and
// one result leaves per query, in order. Difference, product, sum and region
// registers, partial-product and sum registers that square the cross
// product, a register stage per quotient bit in the pipelined restoring
// divider, and one output register follow in turn. A two-entry output buffer
// keeps taking queries while a result waits; when both entries are full
// the whole pipeline holds and query_stall rises until a transfer frees one.
module point_segment_distance_squared_core #(
    parameter int FRAC_BITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                query_valid,
    output logic                query_stall,
    input  psd_pkg::in_item_t   query,
    output logic                result_valid,
    input  logic                result_stall,
    output psd_pkg::out_item_t  result
);

    localparam int LW = psd_pkg::LW;
    localparam int QW = LW + FRAC_BITS;
    localparam int DB = psd_pkg::DIST_BITS;
    localparam int MW = (QW > DB) ? QW : DB;

    logic                      adv;
    logic                      f_valid, s_valid, d_valid;
    logic [psd_pkg::CRW-1:0]   f_cross_mag;
    psd_pkg::side_t            f_side, s_side, d_side;
    logic [2*psd_pkg::CRW-1:0] s_cross_sq;
    logic [QW-1:0]             d_quotient;

    logic [QW-1:0]             alt_fix;
    logic [QW-1:0]             dist_val;
    logic [MW-1:0]             dist_wide;
    psd_pkg::out_item_t        new_item;

    logic                      head_valid_reg, head_valid_next;
    logic                      skid_valid_reg, skid_valid_next;
    psd_pkg::out_item_t        head_reg, head_next;
    psd_pkg::out_item_t        skid_reg, skid_next;
    logic                      push, pop;

    assign adv         = !skid_valid_reg;
    assign query_stall = !adv;

    psd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (query_valid),
        .query     (query),
        .out_valid (f_valid),
        .cross_mag (f_cross_mag),
        .side      (f_side)
    );

    psd_square u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (f_valid),
        .cross_mag (f_cross_mag),
        .in_side   (f_side),
        .out_valid (s_valid),
        .cross_sq  (s_cross_sq),
        .out_side  (s_side)
    );

    psd_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_valid),
        .cross_sq  (s_cross_sq),
        .in_side   (s_side),
        .out_valid (d_valid),
        .quotient  (d_quotient),
        .out_side  (d_side)
    );

    always_comb
    begin
        alt_fix  = QW'(d_side.alt) << FRAC_BITS;
        dist_val = (d_side.region == psd_pkg::REGION_INTERIOR) ? d_quotient : alt_fix;
        dist_wide        = MW'(dist_val);
        new_item.dist_sq = dist_wide[DB-1:0];
        new_item.region  = d_side.region;
    end

    assign push = adv && d_valid;
    assign pop  = head_valid_reg && !result_stall;

    always_comb
    begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (!head_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                head_next       = skid_reg;
                head_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                head_next       = new_item;
                head_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = new_item;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign result_valid = head_valid_reg;
    assign result       = head_reg;

    a_skid_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid entry held without a head entry");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && result_stall) |=> (skid_valid_reg && $stable(skid_reg)))
        else $error("buffered result lost while stalled");

endmodule
